/* rtl/core/lzw_pkg.sv */
`timescale 1ns / 1ps
package lzw_pkg;

    // code word width and dictionary geometry
    localparam int CODE_WIDTH  = 9;
    localparam int ADDR_W      = 9;
    localparam int TABLE_DEPTH = 1 << ADDR_W;
    localparam int CHUNK_CHARS = 8;

    typedef logic [ADDR_W-1:0] t_addr;
    typedef logic [ADDR_W:0]   t_index;
    typedef logic [7:0]        t_char;

    localparam t_index CAPACITY = t_index'(1 << CODE_WIDTH);
    localparam t_addr  BASE_MAX = t_addr'(256);
    localparam t_addr  BASE_MIN = t_addr'(2);

    // clamp a written base size into its legal range
    function automatic t_addr eff_base(input t_addr v);
        t_addr r;
        if (v > BASE_MAX) begin
            r = BASE_MAX;
        end else if (v < BASE_MIN) begin
            r = BASE_MIN;
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

/* rtl/core/lzw_byte_if.sv */
`timescale 1ns / 1ps
interface lzw_byte_if import lzw_pkg::*; ();
    logic  valid;
    logic  ready;
    t_char in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink (input valid, input in_byte, output ready);
endinterface

/* rtl/core/lzw_chunk_if.sv */
`timescale 1ns / 1ps
interface lzw_chunk_if import lzw_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [8*CHUNK_CHARS-1:0] chunk_bytes;
    logic [3:0]               chunk_count;
    logic                     chunk_last;
    logic                     bad_code;

    modport source (output valid, output chunk_bytes, output chunk_count,
                    output chunk_last, output bad_code, input ready);
    modport sink (input valid, input chunk_bytes, input chunk_count,
                  input chunk_last, input bad_code, output ready);
endinterface

/* rtl/core/lzw_stream_decoder.sv */
`timescale 1ns / 1ps
// LZW stream decoder.
// i_in transfers one compressed byte; bits are gathered MSB first into
// 9-bit code words. o_out transfers decoded chunks of up to eight
// characters, earliest character in the low byte; chunk_last marks the
// final chunk of a code, bad_code (count 0) flags a code past the pending
// dictionary entry. i_cfg_we with i_cfg_wdata sets the base size (clamped
// to 2..256) and restarts the dictionary; write it only while idle.
// A code of L characters walks its prefix chain one dictionary entry per
// cycle (one read of the prefix and character memories each), then
// streams the reversed string out of the stack memory one character per
// cycle within a chunk; a stalled receiver holds it between chunks.
// The input is taken again once the last chunk sits in the output register.
// Reset (synchronous) clears the bit buffer, sets base size 256 and starts
// an empty dictionary; memories need no clearing. When the receiver stalls
// the finished chunk holds in the output register and decoding waits.
module lzw_stream_decoder import lzw_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  t_addr         i_cfg_wdata,
    lzw_byte_if.sink      i_in,
    lzw_chunk_if.source   o_out
);

    typedef enum logic [2:0] {
        S_IDLE, S_CHECK, S_WALK, S_FIN, S_EMIT, S_PUSH
    } t_state;

    t_state                   r_state;
    t_addr                    r_base;
    logic [15:0]              r_acc;
    logic [4:0]               r_cnt;
    t_index                   r_next;
    t_addr                    r_code;
    t_addr                    r_e;
    logic                     r_pend;
    t_index                   r_depth;
    t_index                   r_rem;
    logic [3:0]               r_iss;
    logic [3:0]               r_n;
    logic                     r_rd_pend;
    logic                     r_rd_zero;
    t_char                    r_first;
    logic [8*CHUNK_CHARS-1:0] r_buf;
    logic                     r_last;
    logic                     r_bad;
    logic                     r_out_valid;
    logic [8*CHUNK_CHARS-1:0] r_out_bytes;
    logic [3:0]               r_out_count;
    logic                     r_out_last;
    logic                     r_out_bad;

    // dictionary and reverse stack memories
    t_addr r_prefix_mem [TABLE_DEPTH];
    t_char r_lastc_mem  [TABLE_DEPTH];
    t_char r_stack_mem  [TABLE_DEPTH];
    t_addr r_prefix_q;
    t_char r_lastc_q;
    t_char r_stack_q;

    logic [15:0] acc_new;
    logic [4:0]  cnt_sum;
    logic [15:0] acc_shift;
    t_addr       new_code;
    t_index      eff_next;
    t_addr       rd_addr;
    t_addr       stack_rd_addr;
    logic        stack_we;
    t_char       stack_wdata;
    logic        dict_we;
    logic        lastc_we;
    logic        issue;
    t_char       emit_char;
    t_addr       cfg_base;
    logic        push_go;

    // gather bits and cut the next code word
    assign acc_new   = {r_acc[7:0], i_in.in_byte};
    assign cnt_sum   = r_cnt + 5'd8;
    assign acc_shift = acc_new >> (cnt_sum - 5'(CODE_WIDTH));
    assign new_code  = t_addr'(acc_shift[CODE_WIDTH-1:0]);

    // restart when the dictionary is full
    assign eff_next = (r_next >= CAPACITY) ? {1'b0, r_base} : r_next;

    assign rd_addr       = (r_state == S_WALK) ? r_prefix_q : r_code;
    assign stack_rd_addr = t_addr'(r_rem - t_index'(1));
    assign stack_we      = (r_state == S_WALK) || (r_state == S_FIN);
    assign stack_wdata   = (r_state == S_WALK) ? r_lastc_q : r_e[7:0];
    assign dict_we       = (r_state == S_FIN);
    assign lastc_we      = dict_we && (r_next != {1'b0, r_base});
    assign issue         = (r_iss != 4'(CHUNK_CHARS)) && (r_rem != '0);
    assign emit_char     = (r_rd_zero && r_pend) ? r_first : r_stack_q;
    assign cfg_base      = eff_base(i_cfg_wdata);
    assign push_go       = (r_state == S_PUSH) && (!r_out_valid || o_out.ready);

    // dictionary memories: write on entry creation, read every cycle
    always_ff @(posedge i_clk) begin
        if (dict_we) begin
            r_prefix_mem[r_next[ADDR_W-1:0]] <= r_code;
        end
        if (lastc_we) begin
            r_lastc_mem[t_addr'(r_next - t_index'(1))] <= r_e[7:0];
        end
        r_prefix_q <= r_prefix_mem[rd_addr];
        r_lastc_q  <= r_lastc_mem[rd_addr];
    end

    // reverse stack memory
    always_ff @(posedge i_clk) begin
        if (stack_we) begin
            r_stack_mem[r_depth[ADDR_W-1:0]] <= stack_wdata;
        end
        r_stack_q <= r_stack_mem[stack_rd_addr];
    end

    // control sequencer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_base      <= BASE_MAX;
            r_acc       <= '0;
            r_cnt       <= '0;
            r_next      <= {1'b0, BASE_MAX};
            r_out_valid <= 1'b0;
            r_rd_pend   <= 1'b0;
        end else begin
            // drop the output once transferred unless a new chunk replaces it
            if (r_out_valid && o_out.ready && !push_go) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_acc <= acc_new;
                        if (cnt_sum >= 5'(CODE_WIDTH)) begin
                            r_cnt   <= cnt_sum - 5'(CODE_WIDTH);
                            r_code  <= new_code;
                            r_state <= S_CHECK;
                        end else begin
                            r_cnt <= cnt_sum;
                        end
                    end
                end
                S_CHECK: begin
                    r_next <= eff_next;
                    if ({1'b0, r_code} >= eff_next) begin
                        r_buf   <= '0;
                        r_n     <= '0;
                        r_last  <= 1'b1;
                        r_bad   <= 1'b1;
                        r_state <= S_PUSH;
                    end else begin
                        r_pend  <= ({1'b0, r_code} == eff_next - t_index'(1)) &&
                                   (eff_next != {1'b0, r_base});
                        r_e     <= r_code;
                        r_depth <= '0;
                        r_state <= (r_code >= r_base) ? S_WALK : S_FIN;
                    end
                end
                S_WALK: begin
                    // push this entry's character, follow its prefix
                    r_depth <= r_depth + t_index'(1);
                    r_e     <= r_prefix_q;
                    if (r_prefix_q < r_base) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    r_rem     <= r_depth + t_index'(1);
                    r_first   <= r_e[7:0];
                    r_next    <= r_next + t_index'(1);
                    r_iss     <= '0;
                    r_n       <= '0;
                    r_rd_pend <= 1'b0;
                    r_buf     <= '0;
                    r_last    <= 1'b0;
                    r_bad     <= 1'b0;
                    r_state   <= S_EMIT;
                end
                S_EMIT: begin
                    if (r_rd_pend) begin
                        r_buf[{r_n[2:0], 3'b000} +: 8] <= emit_char;
                        r_n <= r_n + 4'd1;
                    end
                    if (issue) begin
                        r_rem     <= r_rem - t_index'(1);
                        r_iss     <= r_iss + 4'd1;
                        r_rd_pend <= 1'b1;
                        r_rd_zero <= (r_rem == t_index'(1));
                    end else begin
                        r_rd_pend <= 1'b0;
                    end
                    if (!r_rd_pend && !issue) begin
                        r_last  <= (r_rem == '0);
                        r_state <= S_PUSH;
                    end
                end
                S_PUSH: begin
                    if (push_go) begin
                        r_out_valid <= 1'b1;
                        r_out_bytes <= r_buf;
                        r_out_count <= r_n;
                        r_out_last  <= r_last;
                        r_out_bad   <= r_bad;
                        if (r_last) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_buf   <= '0;
                            r_n     <= '0;
                            r_iss   <= '0;
                            r_state <= S_EMIT;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
            // base size write restarts the dictionary
            if (i_cfg_we) begin
                r_base <= cfg_base;
                r_next <= {1'b0, cfg_base};
            end
        end
    end

    assign i_in.ready        = (r_state == S_IDLE);
    assign o_out.valid       = r_out_valid;
    assign o_out.chunk_bytes = r_out_bytes;
    assign o_out.chunk_count = r_out_count;
    assign o_out.chunk_last  = r_out_last;
    assign o_out.bad_code    = r_out_bad;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_count <= 4'(CHUNK_CHARS)))
        else $error("chunk count above eight");

    a_bad_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_bad) |-> (r_out_count == '0 && r_out_last))
        else $error("bad code result malformed");

    a_next_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_next <= CAPACITY)
        else $error("next index past capacity");

    a_walk_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK) |-> (r_depth < t_index'(TABLE_DEPTH - 1)))
        else $error("prefix walk too deep");

endmodule

/* tb/sv/tb_lzw_stream_decoder.sv */
`timescale 1ns / 1ps
module tb_lzw_stream_decoder;
    import lzw_pkg::*;

    localparam int CYCLE_LIMIT  = 3000000;
    localparam int SETTLE_CYCLES = 40;
    localparam int MAX_CHUNKS   = 64;

    typedef struct packed {
        logic [63:0] chunk_bytes;
        logic [3:0]  chunk_count;
        logic        chunk_last;
        logic        bad_code;
    } t_chunk;

    // dictionary predictor plus the queue of chunks it expects
    class lzw_scoreboard;
        t_chunk      pending_chunks[$];
        logic [8:0]  base_reg;
        logic [15:0] bit_acc;
        int unsigned bit_cnt;
        int unsigned next_idx;
        logic [8:0]  prefix_mem[TABLE_DEPTH];
        t_char       char_mem[TABLE_DEPTH];
        int          mismatches;
        int          bytes_seen;
        int          chunks_seen;
        int          bad_seen;
        int          restarts;

        function new();
            base_reg   = 9'd256;
            bit_acc    = '0;
            bit_cnt    = 0;
            next_idx   = 256;
            mismatches = 0;
            bytes_seen = 0;
            chunks_seen = 0;
            bad_seen   = 0;
            restarts   = 0;
        endfunction

        function int unsigned base_now();
            if (base_reg > 9'd256) return 256;
            if (base_reg < 9'd2) return 2;
            return base_reg;
        endfunction

        // base size write restarts the dictionary, buffered bits stay
        function void set_base(logic [8:0] v);
            base_reg = v;
            next_idx = base_now();
        endfunction

        function void decode(logic [8:0] code, ref int pos);
            int unsigned base;
            int unsigned e;
            int unsigned depth;
            int unsigned n;
            int unsigned guard;
            t_char       first;
            t_char       stk[TABLE_DEPTH];
            t_chunk      c;
            base = base_now();
            if (next_idx >= CAPACITY) begin
                next_idx = base;
                restarts++;
            end
            // code past the pending entry: one flagged empty chunk
            if (code >= next_idx) begin
                if (pos < MAX_CHUNKS) begin
                    c = '{chunk_bytes: '0, chunk_count: 4'd0, chunk_last: 1'b1,
                          bad_code: 1'b1};
                    pending_chunks.push_back(c);
                    pos++;
                end
                return;
            end
            e = code;
            for (guard = 0; guard < TABLE_DEPTH && e >= base; guard++)
                e = prefix_mem[e];
            first = e[7:0];
            if (next_idx != base)
                char_mem[next_idx - 1] = first;
            prefix_mem[next_idx] = code;
            next_idx++;
            // walk the chain backward, then emit in forward order
            depth = 0;
            e = code;
            while (depth < TABLE_DEPTH - 1 && e >= base) begin
                stk[depth] = char_mem[e];
                depth++;
                e = prefix_mem[e];
            end
            stk[depth] = e[7:0];
            depth++;
            while (depth > 0 && pos < MAX_CHUNKS) begin
                c = '0;
                n = 0;
                while (n < 8 && depth > 0) begin
                    depth--;
                    c.chunk_bytes[8*n +: 8] = stk[depth];
                    n++;
                end
                c.chunk_count = 4'(n);
                c.chunk_last  = (depth == 0);
                pending_chunks.push_back(c);
                pos++;
            end
        endfunction

        // note one accepted compressed byte
        function void note_byte(t_char b);
            int pos;
            pos = 0;
            bytes_seen++;
            bit_acc = {bit_acc[7:0], b};
            bit_cnt = bit_cnt + 8;
            if (bit_cnt > 16) bit_cnt = 16;
            while (bit_cnt >= CODE_WIDTH) begin
                bit_cnt = bit_cnt - CODE_WIDTH;
                decode(9'(bit_acc >> bit_cnt), pos);
            end
        endfunction

        // compare one accepted chunk with the oldest expectation
        function void check_chunk(t_chunk got);
            t_chunk want;
            chunks_seen++;
            if (got.bad_code) bad_seen++;
            if (pending_chunks.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected chunk: bytes=%h count=%0d last=%0b bad=%0b",
                             got.chunk_bytes, got.chunk_count, got.chunk_last,
                             got.bad_code);
                return;
            end
            want = pending_chunks.pop_front();
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("chunk mismatch: exp bytes=%h count=%0d last=%0b bad=%0b",
                             want.chunk_bytes, want.chunk_count, want.chunk_last,
                             want.bad_code);
                    $display("                got bytes=%h count=%0d last=%0b bad=%0b",
                             got.chunk_bytes, got.chunk_count, got.chunk_last,
                             got.bad_code);
                end
            end
        endfunction
    endclass

    logic  i_clk;
    logic  i_rst_n;
    logic  i_cfg_we;
    t_addr i_cfg_wdata;

    lzw_byte_if  in_if();
    lzw_chunk_if out_if();

    lzw_stream_decoder u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (in_if),
        .o_out       (out_if)
    );

    lzw_scoreboard sb = new();
    int            send_idle_pct;
    int            recv_idle_pct;
    int            cycle_cnt;

    // code stream shaping: bit queue and a rough mirror of the dictionary fill
    bit          code_bits[$];
    int unsigned gen_base;
    int unsigned gen_next;

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // run watchdog
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_cnt);
            $display("simulation failed");
            $finish;
        end
    end

    // receive side: check each transfer, then pick the next ready
    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready)
            sb.check_chunk('{chunk_bytes: out_if.chunk_bytes,
                             chunk_count: out_if.chunk_count,
                             chunk_last: out_if.chunk_last,
                             bad_code: out_if.bad_code});
        if (!i_rst_n)
            out_if.ready <= 1'b0;
        else
            out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic send_byte(input t_char b);
        while ($urandom_range(99) < send_idle_pct) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid   <= 1'b1;
        in_if.in_byte <= b;
        do @(posedge i_clk); while (!in_if.ready);
        sb.note_byte(b);
    endtask

    // queue one code MSB first and send every whole byte
    task automatic push_code(input logic [8:0] code);
        if (gen_next >= CAPACITY) gen_next = gen_base;
        if (code < gen_next) gen_next++;
        for (int i = CODE_WIDTH - 1; i >= 0; i--)
            code_bits.push_back(code[i]);
        while (code_bits.size() >= 8) begin
            t_char b;
            for (int i = 7; i >= 0; i--)
                b[i] = code_bits.pop_front();
            send_byte(b);
        end
    endtask

    // mostly valid codes; fill mode favors short strings to reach a full dictionary
    function automatic logic [8:0] pick_code(input bit fill);
        int unsigned nxt;
        int unsigned roll;
        nxt  = (gen_next >= CAPACITY) ? gen_base : gen_next;
        roll = $urandom_range(99);
        if (roll < (fill ? 3 : 10))
            return 9'($urandom_range(CAPACITY - 1, nxt));
        if (roll < (fill ? 13 : 45) && nxt > gen_base)
            return 9'(nxt - 1);
        if (roll < (fill ? 80 : 60))
            return 9'($urandom_range(gen_base - 1));
        return 9'($urandom_range(nxt - 1));
    endfunction

    task automatic wait_drain();
        while (sb.pending_chunks.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_base(input t_addr v);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        sb.set_base(v);
        gen_base = sb.base_now();
        gen_next = gen_base;
    endtask

    task automatic run_phase(input t_addr base, input int mode, input int n_bytes,
                             input bit fill);
        int start;
        start = sb.bytes_seen;
        write_base(base);
        send_idle_pct = (mode == 0) ? 23 : (mode == 1) ? 72 : 0;
        recv_idle_pct = (mode == 0) ? 72 : (mode == 1) ? 23 : 0;
        while (sb.bytes_seen - start < n_bytes)
            push_code(pick_code(fill));
        in_if.valid <= 1'b0;
        wait_drain();
    endtask

    initial begin
        logic [8:0] directed[] = '{9'd0, 9'd255, 9'd256, 9'd257, 9'd511, 9'd300,
                                   9'd65, 9'd258, 9'd259, 9'd256, 9'd0, 9'd511,
                                   9'd170, 9'd85};
        cycle_cnt     = 0;
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_wdata   = '0;
        in_if.valid   = 1'b0;
        in_if.in_byte = '0;
        out_if.ready  = 1'b0;
        send_idle_pct = 23;
        recv_idle_pct = 72;
        gen_base      = 256;
        gen_next      = 256;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: code extremes, pending entry, bad codes at reset base
        foreach (directed[i]) push_code(directed[i]);
        in_if.valid <= 1'b0;
        wait_drain();

        // random phases across base sizes, clamps and idle patterns
        run_phase(9'd2,   0, 20,  1'b0);
        run_phase(9'd300, 0, 310, 1'b1);
        run_phase(9'd0,   1, 20,  1'b0);
        run_phase(9'd100, 1, 20,  1'b0);
        run_phase(9'd511, 2, 15,  1'b0);
        run_phase(9'd7,   2, 15,  1'b0);

        $display("covered %0d compressed bytes, %0d chunks checked, %0d bad codes",
                 sb.bytes_seen, sb.chunks_seen, sb.bad_seen);
        $display("base sizes 2..256 with clamping, %0d full-dictionary restarts",
                 sb.restarts);
        if (sb.mismatches == 0 && sb.pending_chunks.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("%0d mismatches, %0d chunks still expected",
                     sb.mismatches, sb.pending_chunks.size());
            $display("simulation failed");
        end
        $finish;
    end

endmodule
